[src/tcrfs_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tcrfs_pkg: shared types and constants
// Operation codes, status codes, widths and the per-cell control bundle for
// the two-class ratio FIFO scheduler.
// ---------------------------------------------------------------------------
package tcrfs_pkg;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 8;

    // Parameter defaults
    localparam int TCRFS_QUEUE_DEPTH = 16;
    localparam int TCRFS_TAG_BITS    = 8;

    // Run limit after reset
    localparam logic [LIMIT_W-1:0] DEFAULT_RUN_LIMIT = 8'd4;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_DISPATCH = 2'd1,
        FUNC_REMOVE   = 2'd2
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_IDLE    = 2'd3
    } status_t;

    // Per-queue control, broadcast to every cell of the row
    typedef struct packed {
        logic push;     // append tag at the tail
        logic pop;      // drop the head, shift all toward head
        logic rm;       // drop oldest matching entry
    } cell_ctl_t;

endpackage
`default_nettype wire

[src/tcrfs_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tcrfs_if: channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------

// Request channel
interface tcrfs_req_if;
    logic                       valid;
    logic                       ready;
    logic [tcrfs_pkg::FUNC_W-1:0] func;
    logic [tcrfs_pkg::TAG_W-1:0]  request_tag;
    logic                       request_class;

    modport source (output valid, output func, output request_tag,
                    output request_class, input ready);
    modport sink   (input valid, input func, input request_tag,
                    input request_class, output ready);
endinterface

// Result channel
interface tcrfs_res_if;
    logic                         valid;
    logic                         ready;
    logic                         granted;
    logic [tcrfs_pkg::TAG_W-1:0]    grant_tag;
    logic                         grant_class;
    logic [tcrfs_pkg::STATUS_W-1:0] status;

    modport source (output valid, output granted, output grant_tag,
                    output grant_class, output status, input ready);
    modport sink   (input valid, input granted, input grant_tag,
                    input grant_class, input status, output ready);
endinterface

// Configuration write channel (run limit)
interface tcrfs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tcrfs_pkg::LIMIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/tcrfs_cell.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tcrfs_cell: one queue slot
// Holds a valid bit and a tag, compares against the broadcast tag, passes
// the first-match chain on, and loads from its neighbor when the row shifts.
// ---------------------------------------------------------------------------
module tcrfs_cell #(
    parameter int TAG_BITS = tcrfs_pkg::TCRFS_TAG_BITS
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  tcrfs_pkg::cell_ctl_t     ctl,
    input  wire  [TAG_BITS-1:0]      cmp_tag,
    input  wire                      prev_valid,
    input  wire                      next_valid,
    input  wire  [TAG_BITS-1:0]      next_tag,
    input  wire                      hit_in,
    output logic                     hit_out,
    output logic                     valid,
    output logic [TAG_BITS-1:0]      tag
);
    import tcrfs_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;
    logic                match;
    logic                shift;
    logic                load;

    // Match chain: hit_out is high from the oldest match onward
    assign match   = valid_reg && (tag_reg == cmp_tag);
    assign hit_out = hit_in | match;

    // Shift on pop, or on remove at or behind the oldest match
    assign shift = ctl.pop | (ctl.rm & hit_out);
    // Load at the first empty slot
    assign load  = ctl.push & ~valid_reg & prev_valid;

    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        if (shift)
        begin
            valid_next = next_valid;
            tag_next   = next_tag;
        end
        else if (load)
        begin
            valid_next = 1'b1;
            tag_next   = cmp_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Tag payload, no reset
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;

endmodule
`default_nettype wire

[src/tcrfs_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tcrfs_queue: one class queue as a row of cells
// Cell 0 is the head. Entries stay packed toward the head: push fills the
// first empty cell, pop and remove shift the tail part one cell forward.
// ---------------------------------------------------------------------------
module tcrfs_queue #(
    parameter int QUEUE_DEPTH = tcrfs_pkg::TCRFS_QUEUE_DEPTH,
    parameter int TAG_BITS    = tcrfs_pkg::TCRFS_TAG_BITS
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  tcrfs_pkg::cell_ctl_t     ctl,
    input  wire  [TAG_BITS-1:0]      cmp_tag,
    output logic                     empty,
    output logic                     full,
    output logic                     found,
    output logic [TAG_BITS-1:0]      head_tag
);
    import tcrfs_pkg::*;

    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic [TAG_BITS-1:0]    tag_arr [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]   hit_chain;

    assign hit_chain[0] = 1'b0;

    // Row of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                prev_v;
        logic                next_v;
        logic [TAG_BITS-1:0] next_t;

        if (i == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_body
            assign prev_v = valid_vec[i-1];
        end

        if (i == QUEUE_DEPTH-1)
        begin : g_tail
            assign next_v = 1'b0;
            assign next_t = '0;
        end
        else
        begin : g_inner
            assign next_v = valid_vec[i+1];
            assign next_t = tag_arr[i+1];
        end

        tcrfs_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cmp_tag    (cmp_tag),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_tag   (next_t),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .valid      (valid_vec[i]),
            .tag        (tag_arr[i])
        );
    end

    // Status toward the scheduler
    assign empty    = ~valid_vec[0];
    assign full     = valid_vec[QUEUE_DEPTH-1];
    assign found    = hit_chain[QUEUE_DEPTH];
    assign head_tag = tag_arr[0];

`ifndef SYNTHESIS
    // Valid cells always form a packed run starting at the head
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
        else $error("queue entries not packed toward head");

    // Push into a full queue keeps the occupancy
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.push && full) |=> $stable(valid_vec))
        else $error("push into full queue changed occupancy");

    // Pop of the last entry empties the queue
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.pop && !ctl.push && !ctl.rm && valid_vec[0]
         && (valid_vec == QUEUE_DEPTH'(1))) |=> empty)
        else $error("pop of last entry left queue nonempty");
`endif

endmodule
`default_nettype wire

[src/two_class_ratio_fifo_scheduler.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// two_class_ratio_fifo_scheduler: weighted two-queue request scheduler
// The result is registered: it is valid in the cycle after the request transfer.
// Throughput: one item per cycle while results are taken; add, dispatch and
// remove each finish in the cycle of transfer, the tag compare running in parallel in every queue cell.
// Reset: queues empty, run counter 0, run limit 4; slot tags are not cleared.
// ---------------------------------------------------------------------------
module two_class_ratio_fifo_scheduler #(
    parameter int QUEUE_DEPTH = tcrfs_pkg::TCRFS_QUEUE_DEPTH,
    parameter int TAG_BITS    = tcrfs_pkg::TCRFS_TAG_BITS
) (
    input  wire         clk,
    input  wire         rst_n,
    tcrfs_req_if.sink   req,
    tcrfs_res_if.source res,
    tcrfs_cfg_if.sink   cfg
);
    import tcrfs_pkg::*;

    logic                  accept;
    logic                  is_add;
    logic                  is_disp;
    logic                  is_rm;
    logic [TAG_BITS-1:0]   cmp_tag;
    logic [TAG_BITS+TAG_W-1:0] tag_in_ext;
    logic [TAG_BITS+TAG_W-1:0] tag_out_ext;

    cell_ctl_t             ctl0;
    cell_ctl_t             ctl1;
    logic                  empty0, empty1;
    logic                  full0, full1;
    logic                  found0, found1;
    logic [TAG_BITS-1:0]   head0, head1;

    logic                  favored_ok;
    logic                  grant0;
    logic                  grant1;

    logic [LIMIT_W-1:0]    limit_reg;
    logic [LIMIT_W-1:0]    run_counter_reg;
    logic [LIMIT_W-1:0]    run_counter_next;

    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic                  granted_reg, granted_next;
    logic [TAG_W-1:0]      grant_tag_reg, grant_tag_next;
    logic                  grant_class_reg, grant_class_next;
    status_t               status_reg, status_next;

    // Handshakes: output register frees when the result is taken
    assign req.ready = ~res_valid_reg | res.ready;
    assign accept    = req.valid & req.ready;
    assign cfg.ready = 1'b1;

    // Operation decode
    always_comb
    begin
        is_add  = 1'b0;
        is_disp = 1'b0;
        is_rm   = 1'b0;
        unique case (req.func)
            FUNC_ADD:      is_add  = accept;
            FUNC_DISPATCH: is_disp = accept;
            FUNC_REMOVE:   is_rm   = accept;
            default:       ;
        endcase
    end

    // Tag width adaptation between the 8-bit field and stored tags
    assign tag_in_ext  = {{TAG_BITS{1'b0}}, req.request_tag};
    assign cmp_tag     = tag_in_ext[TAG_BITS-1:0];

    // Grant decision
    assign favored_ok = run_counter_reg < limit_reg;
    assign grant0     = is_disp & favored_ok & ~empty0;
    assign grant1     = is_disp & ~grant0 & ~empty1;

    // Queue controls; class 1 removal only when class 0 has no match
    assign ctl0.push = is_add & ~req.request_class;
    assign ctl0.pop  = grant0;
    assign ctl0.rm   = is_rm;
    assign ctl1.push = is_add & req.request_class;
    assign ctl1.pop  = grant1;
    assign ctl1.rm   = is_rm & ~found0;

    tcrfs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_favored_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl0),
        .cmp_tag  (cmp_tag),
        .empty    (empty0),
        .full     (full0),
        .found    (found0),
        .head_tag (head0)
    );

    tcrfs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_other_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl1),
        .cmp_tag  (cmp_tag),
        .empty    (empty1),
        .full     (full1),
        .found    (found1),
        .head_tag (head1)
    );

    assign tag_out_ext = {{TAG_W{1'b0}}, (grant0 ? head0 : head1)};

    // Run counter: count class 0 grants, clear on any other dispatch
    always_comb
    begin
        run_counter_next = run_counter_reg;
        if (grant0)
            run_counter_next = run_counter_reg + LIMIT_W'(1);
        else if (is_disp)
            run_counter_next = '0;
    end

    // Result fields
    always_comb
    begin
        granted_next     = 1'b0;
        grant_tag_next   = '0;
        grant_class_next = 1'b0;
        status_next      = ST_OK;
        unique case (req.func)
            FUNC_ADD:
            begin
                if (req.request_class ? full1 : full0)
                    status_next = ST_FULL;
            end
            FUNC_DISPATCH:
            begin
                if (grant0 | grant1)
                begin
                    granted_next     = 1'b1;
                    grant_tag_next   = tag_out_ext[TAG_W-1:0];
                    grant_class_next = grant1;
                end
                else
                    status_next = ST_IDLE;
            end
            FUNC_REMOVE:
            begin
                if (!(found0 | found1))
                    status_next = ST_MISSING;
            end
            default: ;
        endcase
    end

    assign res_valid_next = accept ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg   <= 1'b0;
            run_counter_reg <= '0;
            limit_reg       <= DEFAULT_RUN_LIMIT;
        end
        else
        begin
            res_valid_reg   <= res_valid_next;
            run_counter_reg <= run_counter_next;
            if (cfg.valid && cfg.ready)
                limit_reg <= cfg.data;
        end
    end

    // Result payload, loaded on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            granted_reg     <= granted_next;
            grant_tag_reg   <= grant_tag_next;
            grant_class_reg <= grant_class_next;
            status_reg      <= status_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.granted     = granted_reg;
    assign res.grant_tag   = grant_tag_reg;
    assign res.grant_class = grant_class_reg;
    assign res.status      = status_reg;

`ifndef SYNTHESIS
    // A class 0 grant advances the run counter by one
    a_run_inc: assert property (@(posedge clk) disable iff (!rst_n)
        grant0 |=> run_counter_reg == $past(run_counter_reg) + LIMIT_W'(1))
        else $error("run counter did not advance on class 0 grant");

    // Class 0 is never granted at or above the limit
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        grant0 |-> run_counter_reg < limit_reg)
        else $error("class 0 granted past run limit");

    // Never both queues popped in one dispatch
    a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl0.pop && ctl1.pop))
        else $error("both queues popped in one transfer");
`endif

endmodule
`default_nettype wire

[bench/two_class_ratio_fifo_scheduler_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_class_ratio_fifo_scheduler_tb: self-checking bench for the scheduler
// Drives add, dispatch and remove requests with bursty timing. A tracker
// mirrors both tag queues, the run counter and the run limit. It predicts
// one result per request and compares every result transfer against it.
// The run limit is changed between phases while the block is drained.
// ---------------------------------------------------------------------------
module two_class_ratio_fifo_scheduler_tb;
    import tcrfs_pkg::*;

    localparam int QDEPTH      = TCRFS_QUEUE_DEPTH;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 128;
    localparam int DRAIN_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic                granted;
        logic [TAG_W-1:0]    grant_tag;
        logic                grant_class;
        status_t             status;
    } sched_result_t;

    // Mirror of both queues and the ratio state; holds the expected results
    class dispatch_tracker;
        logic [TAG_W-1:0]   favored_tags[$];
        logic [TAG_W-1:0]   other_tags[$];
        logic [LIMIT_W-1:0] run_count;
        logic [LIMIT_W-1:0] run_limit;
        sched_result_t      pending_results[$];
        int                 errors;

        function new();
            run_count = '0;
            run_limit = DEFAULT_RUN_LIMIT;
            errors    = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            run_limit = value;
        endfunction

        // Apply one accepted request and queue its outcome
        function void note_request(func_t f, logic [TAG_W-1:0] tag, logic cls);
            sched_result_t r;
            int            hit[$];
            r.granted     = 1'b0;
            r.grant_tag   = '0;
            r.grant_class = 1'b0;
            r.status      = ST_OK;
            case (f)
                FUNC_ADD:
                begin
                    if (cls)
                    begin
                        if (other_tags.size() >= QDEPTH)
                            r.status = ST_FULL;
                        else
                            other_tags.push_back(tag);
                    end
                    else
                    begin
                        if (favored_tags.size() >= QDEPTH)
                            r.status = ST_FULL;
                        else
                            favored_tags.push_back(tag);
                    end
                end
                FUNC_DISPATCH:
                begin
                    if (run_count < run_limit && favored_tags.size() > 0)
                    begin
                        run_count   = run_count + 1'b1;
                        r.granted   = 1'b1;
                        r.grant_tag = favored_tags.pop_front();
                    end
                    else if (other_tags.size() > 0)
                    begin
                        run_count     = '0;
                        r.granted     = 1'b1;
                        r.grant_tag   = other_tags.pop_front();
                        r.grant_class = 1'b1;
                    end
                    else
                    begin
                        run_count = '0;
                        r.status  = ST_IDLE;
                    end
                end
                FUNC_REMOVE:
                begin
                    // oldest copy goes, favored queue searched first
                    hit = favored_tags.find_first_index(x) with (x == tag);
                    if (hit.size() > 0)
                        favored_tags.delete(hit[0]);
                    else
                    begin
                        hit = other_tags.find_first_index(x) with (x == tag);
                        if (hit.size() > 0)
                            other_tags.delete(hit[0]);
                        else
                            r.status = ST_MISSING;
                    end
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic granted, logic [TAG_W-1:0] grant_tag,
                                   logic grant_class, logic [STATUS_W-1:0] status);
            sched_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (granted !== want.granted)
            begin
                $error("granted: expected %0d, actual %0d", want.granted, granted);
                errors++;
            end
            if (grant_tag !== want.grant_tag)
            begin
                $error("grant_tag: expected %0h, actual %0h", want.grant_tag, grant_tag);
                errors++;
            end
            if (grant_class !== want.grant_class)
            begin
                $error("grant_class: expected %0d, actual %0d", want.grant_class,
                       grant_class);
                errors++;
            end
            if (status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   long_hold_req = 1'b0;

    dispatch_tracker sb = new();

    tcrfs_req_if req_bus ();
    tcrfs_res_if res_bus ();
    tcrfs_cfg_if cfg_bus ();

    two_class_ratio_fifo_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Offer one request and hold it until the transfer
    task automatic send_request(func_t f, logic [TAG_W-1:0] tag, logic cls);
        req_bus.valid         <= 1'b1;
        req_bus.func          <= f;
        req_bus.request_tag   <= tag;
        req_bus.request_class <= cls;
        do
            @(posedge clk);
        while (!req_bus.ready);
        sb.note_request(f, tag, cls);
    endtask

    task automatic idle_requests(int cycles);
        req_bus.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Wait until every expected result has arrived, then let the pipe settle
    task automatic wait_drained();
        int waited;
        waited = 0;
        while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending_results.size() != 0)
        begin
            $error("results still outstanding: %0d", sb.pending_results.size());
            sb.errors++;
            sb.pending_results.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        sb.set_limit(value);
        @(posedge clk);
    endtask

    // Random request; removes mostly target a tag that is queued
    task automatic pick_request(input int add_pct, input int disp_pct, input int fav_pct,
                                output func_t f, output logic [TAG_W-1:0] tag,
                                output logic cls);
        int roll;
        int held;
        int idx;
        roll = $urandom_range(0, 99);
        held = sb.favored_tags.size() + sb.other_tags.size();
        cls  = ($urandom_range(0, 99) >= fav_pct);
        if ($urandom_range(0, 1) == 0)
            tag = TAG_W'($urandom_range(0, 7));
        else
            tag = TAG_W'($urandom_range(0, 255));
        if (roll < add_pct)
            f = FUNC_ADD;
        else if (roll < add_pct + disp_pct)
            f = FUNC_DISPATCH;
        else
        begin
            f = FUNC_REMOVE;
            if (held > 0 && $urandom_range(0, 9) < 7)
            begin
                idx = $urandom_range(0, held - 1);
                if (idx < sb.favored_tags.size())
                    tag = sb.favored_tags[idx];
                else
                    tag = sb.other_tags[idx - sb.favored_tags.size()];
            end
        end
    endtask

    // Result sink: checks transfers, stalls on its own pattern
    initial
    begin : result_sink
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        res_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_bus.valid && res_bus.ready)
                sb.check_result(res_bus.granted, res_bus.grant_tag,
                                res_bus.grant_class, res_bus.status);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES;
            end
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       res_bus.ready <= 1'b1;
                    1:       res_bus.ready <= ($urandom_range(0, 99) < 65);
                    default: res_bus.ready <= ((tick % 4) != 3);
                endcase
            end
        end
    end

    // Stimulus: directed checks, then random phases at several run limits
    initial
    begin : stimulus
        func_t              f;
        logic [TAG_W-1:0]   tag;
        logic               cls;
        int                 sent;
        int                 burst;
        int                 gap;
        int                 add_pct;
        int                 disp_pct;
        int                 fav_pct;
        bit                 pressure;
        logic [LIMIT_W-1:0] phase_limit [PHASES];

        phase_limit = '{8'd0, 8'd255, 8'd1, LIMIT_W'($urandom_range(1, 254)), 8'd2,
                        8'd255, 8'd3, LIMIT_W'($urandom_range(1, 254)), 8'd0, 8'd4};

        rst_n                 <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.func          <= FUNC_ADD;
        req_bus.request_tag   <= '0;
        req_bus.request_class <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.data          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset run limit
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);   // nothing queued
        send_request(FUNC_REMOVE,   8'h00, 1'b0);   // tag held nowhere
        send_request(FUNC_ADD,      8'h00, 1'b0);
        send_request(FUNC_ADD,      8'hFF, 1'b0);
        send_request(FUNC_ADD,      8'hFF, 1'b1);   // same tag in both classes
        send_request(FUNC_ADD,      8'hAA, 1'b1);
        send_request(FUNC_ADD,      8'h55, 1'b0);
        send_request(FUNC_ADD,      8'h00, 1'b0);   // duplicate in one class
        send_request(FUNC_REMOVE,   8'hFF, 1'b1);   // favored copy goes first
        send_request(FUNC_REMOVE,   8'h00, 1'b0);   // oldest copy goes
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);   // favored empty, other served
        send_request(FUNC_ADD,      8'h01, 1'b0);
        send_request(FUNC_ADD,      8'h02, 1'b0);
        send_request(FUNC_ADD,      8'h03, 1'b0);
        send_request(FUNC_ADD,      8'h04, 1'b0);
        send_request(FUNC_ADD,      8'h05, 1'b0);
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);   // run limit hit, other served
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);
        send_request(FUNC_DISPATCH, 8'h00, 1'b0);   // both queues empty, idle
        idle_requests(1);

        // Random phases; the limit changes only while drained
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_limit(phase_limit[p]);
            add_pct  = (p % 2 == 0) ? 55 : 35;
            disp_pct = (p % 2 == 0) ? 30 : 50;
            fav_pct  = (phase_limit[p] == 8'd255) ? 80 : 50;
            pressure = (p == 3);
            if (pressure)
                long_hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = pressure ? PHASE_ITEMS : $urandom_range(1, 40);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++)
                begin
                    pick_request(add_pct, disp_pct, fav_pct, f, tag, cls);
                    send_request(f, tag, cls);
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0 && sent < PHASE_ITEMS)
                    idle_requests(gap);
            end
            idle_requests(1);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
